// ----- sv/swhr_pkg.sv -----
package swhr_pkg;

  // frame layout
  localparam int unsigned FRAME_BITS = 40;
  localparam int unsigned BIT_IDX_W  = $clog2(FRAME_BITS + 1);
  localparam int unsigned TICK_W     = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_START_LOW_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TIMEOUT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT      = 3'd4;

  localparam logic [15:0] RST_START_LOW_TICKS = 16'd20000;
  localparam logic [7:0]  RST_RELEASE_TICKS   = 8'd30;
  localparam logic [9:0]  RST_LEVEL_TIMEOUT   = 10'd100;
  localparam logic [9:0]  RST_ONE_THRESHOLD   = 10'd40;
  localparam logic [9:0]  RST_HIGH_LIMIT      = 10'd100;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_LOW   = 3'd1;
  localparam logic [2:0] ST_NO_HIGH  = 3'd2;
  localparam logic [2:0] ST_BIT_TO   = 3'd3;
  localparam logic [2:0] ST_CHECKSUM = 3'd4;

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_START_LOW = 8'b0000_0010,
    PH_RELEASE   = 8'b0000_0100,
    PH_RESP_LOW  = 8'b0000_1000,
    PH_RESP_HIGH = 8'b0001_0000,
    PH_BIT_LOW   = 8'b0010_0000,
    PH_BIT_HIGH  = 8'b0100_0000,
    PH_MEASURE   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [15:0] start_low_ticks;
    logic [7:0]  release_ticks;
    logic [9:0]  level_timeout;
    logic [9:0]  one_threshold;
    logic [9:0]  high_limit;
  } cfg_t;

  typedef struct packed {
    logic action;
    logic pin_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] humidity;
    logic [7:0] temperature;
  } out_item_t;

endpackage

// ----- sv/swhr_cfg.sv -----
module swhr_cfg
  import swhr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_low_ticks <= RST_START_LOW_TICKS;
      regs.release_ticks   <= RST_RELEASE_TICKS;
      regs.level_timeout   <= RST_LEVEL_TIMEOUT;
      regs.one_threshold   <= RST_ONE_THRESHOLD;
      regs.high_limit      <= RST_HIGH_LIMIT;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_START_LOW_TICKS: regs.start_low_ticks <= cfg_wdata;
        REG_RELEASE_TICKS:   regs.release_ticks   <= cfg_wdata[7:0];
        REG_LEVEL_TIMEOUT:   regs.level_timeout   <= cfg_wdata[9:0];
        REG_ONE_THRESHOLD:   regs.one_threshold   <= cfg_wdata[9:0];
        REG_HIGH_LIMIT:      regs.high_limit      <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ----- sv/swhr_core.sv -----
module swhr_core
  import swhr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      acc,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  phase_t                phase, phase_next;
  logic [TICK_W-1:0]     tick_count, tick_count_next;
  logic [BIT_IDX_W-1:0]  bit_index, bit_index_next;
  logic [FRAME_BITS-1:0] frame_shift, frame_shift_next;
  logic [2:0]            last_status, last_status_next;
  logic [7:0]            humidity_reg, humidity_reg_next;
  logic [7:0]            temperature_reg, temperature_reg_next;

  logic [TICK_W-1:0]     tick_inc;
  logic                  wait_to;
  logic                  do_end;
  logic [TICK_W-1:0]     end_cnt;
  logic                  fin;
  logic [2:0]            fin_code;
  logic                  bit_val;
  logic [FRAME_BITS-1:0] frame_sh;
  logic [BIT_IDX_W-1:0]  bit_inc;
  logic [7:0]            byte_sum;

  assign tick_inc = tick_count + TICK_W'(1);
  assign wait_to  = tick_inc > TICK_W'(cfg.level_timeout);

  always_comb begin
    phase_next           = phase;
    tick_count_next      = tick_count;
    bit_index_next       = bit_index;
    frame_shift_next     = frame_shift;
    last_status_next     = last_status;
    humidity_reg_next    = humidity_reg;
    temperature_reg_next = temperature_reg;
    do_end               = 1'b0;
    end_cnt              = tick_count;
    fin                  = 1'b0;
    fin_code             = ST_OK;

    if (item.action) begin
      if (phase == PH_IDLE) begin
        phase_next       = PH_START_LOW;
        tick_count_next  = '0;
        bit_index_next   = '0;
        frame_shift_next = '0;
      end
    end else begin
      case (phase)
        PH_START_LOW: begin
          tick_count_next = tick_inc;
          if (tick_inc >= cfg.start_low_ticks) begin
            phase_next      = PH_RELEASE;
            tick_count_next = '0;
          end
        end
        PH_RELEASE: begin
          tick_count_next = tick_inc;
          if (tick_inc >= TICK_W'(cfg.release_ticks)) begin
            phase_next      = PH_RESP_LOW;
            tick_count_next = '0;
          end
        end
        PH_RESP_LOW: begin
          if (!item.pin_level) begin
            tick_count_next = '0;
            phase_next      = PH_RESP_HIGH;
          end else begin
            tick_count_next = tick_inc;
            if (wait_to) begin
              fin      = 1'b1;
              fin_code = ST_NO_LOW;
            end
          end
        end
        PH_RESP_HIGH: begin
          if (item.pin_level) begin
            tick_count_next = '0;
            phase_next      = PH_BIT_LOW;
          end else begin
            tick_count_next = tick_inc;
            if (wait_to) begin
              fin      = 1'b1;
              fin_code = ST_NO_HIGH;
            end
          end
        end
        PH_BIT_LOW: begin
          if (!item.pin_level) begin
            tick_count_next = '0;
            phase_next      = PH_BIT_HIGH;
          end else begin
            tick_count_next = tick_inc;
            if (wait_to) begin
              fin      = 1'b1;
              fin_code = ST_BIT_TO;
            end
          end
        end
        PH_BIT_HIGH: begin
          if (item.pin_level) begin
            // the edge tick is the first high tick
            phase_next      = PH_MEASURE;
            tick_count_next = TICK_W'(1);
            if (TICK_W'(1) > TICK_W'(cfg.high_limit)) begin
              do_end  = 1'b1;
              end_cnt = TICK_W'(1);
            end
          end else begin
            tick_count_next = tick_inc;
            if (wait_to) begin
              fin      = 1'b1;
              fin_code = ST_BIT_TO;
            end
          end
        end
        PH_MEASURE: begin
          if (item.pin_level) begin
            tick_count_next = tick_inc;
            if (tick_inc > TICK_W'(cfg.high_limit)) begin
              do_end  = 1'b1;
              end_cnt = tick_inc;
            end
          end else begin
            do_end  = 1'b1;
            end_cnt = tick_count;
          end
        end
        default: ;
      endcase
    end

    // bit decode and frame check
    bit_val  = end_cnt > TICK_W'(cfg.one_threshold);
    frame_sh = {frame_shift[FRAME_BITS-2:0], bit_val};
    bit_inc  = bit_index + BIT_IDX_W'(1);
    byte_sum = frame_sh[39:32] + frame_sh[31:24] + frame_sh[23:16] + frame_sh[15:8];

    if (do_end) begin
      frame_shift_next = frame_sh;
      bit_index_next   = bit_inc;
      tick_count_next  = '0;
      if (bit_inc >= BIT_IDX_W'(FRAME_BITS)) begin
        fin = 1'b1;
        if (byte_sum != frame_sh[7:0]) begin
          fin_code = ST_CHECKSUM;
        end else begin
          fin_code             = ST_OK;
          humidity_reg_next    = frame_sh[39:32];
          temperature_reg_next = frame_sh[23:16];
        end
      end else begin
        phase_next = PH_BIT_LOW;
      end
    end

    if (fin) begin
      last_status_next = fin_code;
      phase_next       = PH_IDLE;
      tick_count_next  = '0;
    end

    res.drive_low   = (phase_next == PH_START_LOW);
    res.busy_res    = (phase_next != PH_IDLE);
    res.done_res    = fin;
    res.status      = last_status_next;
    res.humidity    = humidity_reg_next;
    res.temperature = temperature_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      tick_count      <= '0;
      bit_index       <= '0;
      frame_shift     <= '0;
      last_status     <= ST_OK;
      humidity_reg    <= '0;
      temperature_reg <= '0;
    end else if (acc) begin
      phase           <= phase_next;
      tick_count      <= tick_count_next;
      bit_index       <= bit_index_next;
      frame_shift     <= frame_shift_next;
      last_status     <= last_status_next;
      humidity_reg    <= humidity_reg_next;
      temperature_reg <= temperature_reg_next;
    end
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    acc && res.done_res |=> phase == PH_IDLE)
    else $error("finished transaction left the reader busy");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= BIT_IDX_W'(FRAME_BITS))
    else $error("bit index ran past the frame");

  a_hum_on_ok: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && humidity_reg != $past(humidity_reg)
      |-> $past(acc && res.done_res) && last_status == ST_OK)
    else $error("humidity changed without a good frame");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    acc && item.action && phase == PH_IDLE |=> bit_index == '0 && frame_shift == '0)
    else $error("read request did not clear the frame");
`endif

endmodule

// ----- sv/swhr_obuf.sv -----
module swhr_obuf
  import swhr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_data,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  out_item_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("result written into a full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("result buffer count out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("buffer pointers disagree with count");
`endif

endmodule

// ----- sv/single_wire_humidity_sensor_reader_top.sv -----
// Host side of a single-wire humidity and temperature sensor link. Each input
// transaction is one microsecond tick carrying the sampled data-line level
// (action 0) or a read request (action 1); each accepted input transaction
// produces exactly one result transaction showing drive_low, busy, done,
// the last status and the last good humidity and temperature bytes. A
// request pulls the line low for start_low_ticks, releases it for
// release_ticks, waits for the sensor's low and high response and then
// measures 40 high pulses; a pulse above one_threshold is a one. Status 0 ok,
// 1 no response low, 2 no response high, 3 bit timeout, 4 checksum. Every
// item is handled by the reader state machine as it is accepted, so an input
// transaction can be accepted on every clock; results pass through a
// two-entry output buffer and in_stall rises only while that buffer is full.
// Configuration registers (index: 0 start_low_ticks, 1 release_ticks,
// 2 level_timeout, 3 one_threshold, 4 high_limit) are written through
// cfg_we / cfg_idx / cfg_wdata and should only change while idle.
module single_wire_humidity_sensor_reader_top
  import swhr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  out_item_t res;
  logic      acc;
  logic      full;

  // an input transaction is taken whenever the result buffer has room
  assign in_stall = full;
  assign acc      = in_valid && !full;

  // register file for the timing settings
  swhr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // protocol state machine, bit decode and checksum
  swhr_core u_core (
    .clk  (clk),
    .rst  (rst),
    .acc  (acc),
    .item (in_data),
    .cfg  (cfg),
    .res  (res)
  );

  // result buffer, decouples the two sides
  swhr_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (acc),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- dv/single_wire_humidity_sensor_reader_top_test.sv -----
`timescale 1ns / 100ps

module single_wire_humidity_sensor_reader_top_test;
  import swhr_pkg::*;

  // clock, reset and the three ports of the reader
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // idling of each side, in cycles out of a hundred
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  int error_count = 0;
  int items_sent  = 0;

  // readings still owed by the block, oldest first
  out_item_t expected_readings[$];

  // our own copy of the reader: settings and state
  cfg_t                  reader_cfg;
  phase_t                rd_phase;
  logic [15:0]           rd_ticks;
  logic [5:0]            rd_bits;
  logic [FRAME_BITS-1:0] rd_frame;
  logic [2:0]            rd_status;
  logic [7:0]            rd_humid;
  logic [7:0]            rd_temp;
  logic                  rd_done;

  single_wire_humidity_sensor_reader_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // receiver back-pressure, changed only on the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // reading predictor
  // ---------------------------------------------------------------------------

  function automatic void finish_read(input logic [2:0] code);
    rd_status = code;
    rd_phase  = PH_IDLE;
    rd_ticks  = '0;
    rd_done   = 1'b1;
  endfunction

  // 1 once the line shows the wanted level, -1 when the wrong level has lasted
  // past the timeout, 0 while still waiting
  function automatic int await_level(input logic lvl, input logic pin);
    if (pin == lvl) begin
      rd_ticks = '0;
      return 1;
    end
    rd_ticks = rd_ticks + 16'd1;
    if (rd_ticks > 16'(reader_cfg.level_timeout)) return -1;
    return 0;
  endfunction

  // shift in the measured bit; after the last one check the byte sum
  function automatic void close_bit();
    logic [7:0] sum;
    rd_frame = {rd_frame[FRAME_BITS-2:0], (rd_ticks > 16'(reader_cfg.one_threshold))};
    rd_bits  = rd_bits + 6'd1;
    rd_ticks = '0;
    if (rd_bits >= 6'(FRAME_BITS)) begin
      sum = rd_frame[39:32] + rd_frame[31:24] + rd_frame[23:16] + rd_frame[15:8];
      if (sum != rd_frame[7:0]) begin
        finish_read(ST_CHECKSUM);
      end else begin
        rd_humid = rd_frame[39:32];
        rd_temp  = rd_frame[23:16];
        finish_read(ST_OK);
      end
    end else begin
      rd_phase = PH_BIT_LOW;
    end
  endfunction

  function automatic out_item_t predict_reading(input in_item_t txn);
    out_item_t reading;
    int        verdict;
    rd_done = 1'b0;
    if (txn.action) begin
      // a request only counts while idle
      if (rd_phase == PH_IDLE) begin
        rd_phase = PH_START_LOW;
        rd_ticks = '0;
        rd_bits  = '0;
        rd_frame = '0;
      end
    end else begin
      case (rd_phase)
        PH_START_LOW: begin
          rd_ticks = rd_ticks + 16'd1;
          if (rd_ticks >= reader_cfg.start_low_ticks) begin
            rd_phase = PH_RELEASE;
            rd_ticks = '0;
          end
        end
        PH_RELEASE: begin
          rd_ticks = rd_ticks + 16'd1;
          if (rd_ticks >= 16'(reader_cfg.release_ticks)) begin
            rd_phase = PH_RESP_LOW;
            rd_ticks = '0;
          end
        end
        PH_RESP_LOW: begin
          verdict = await_level(1'b0, txn.pin_level);
          if (verdict > 0) rd_phase = PH_RESP_HIGH;
          else if (verdict < 0) finish_read(ST_NO_LOW);
        end
        PH_RESP_HIGH: begin
          verdict = await_level(1'b1, txn.pin_level);
          if (verdict > 0) rd_phase = PH_BIT_LOW;
          else if (verdict < 0) finish_read(ST_NO_HIGH);
        end
        PH_BIT_LOW: begin
          verdict = await_level(1'b0, txn.pin_level);
          if (verdict > 0) rd_phase = PH_BIT_HIGH;
          else if (verdict < 0) finish_read(ST_BIT_TO);
        end
        PH_BIT_HIGH: begin
          verdict = await_level(1'b1, txn.pin_level);
          if (verdict > 0) begin
            // the rising tick is already the first high tick
            rd_phase = PH_MEASURE;
            rd_ticks = 16'd1;
            if (rd_ticks > 16'(reader_cfg.high_limit)) close_bit();
          end else if (verdict < 0) begin
            finish_read(ST_BIT_TO);
          end
        end
        PH_MEASURE: begin
          if (txn.pin_level) begin
            rd_ticks = rd_ticks + 16'd1;
            if (rd_ticks > 16'(reader_cfg.high_limit)) close_bit();
          end else begin
            close_bit();
          end
        end
        default: ;
      endcase
    end
    reading.drive_low   = (rd_phase == PH_START_LOW);
    reading.busy_res    = (rd_phase != PH_IDLE);
    reading.done_res    = rd_done;
    reading.status      = rd_status;
    reading.humidity    = rd_humid;
    reading.temperature = rd_temp;
    return reading;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : check_readings
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        $error("result transaction with no reading pending: %p", out_data);
        error_count++;
      end else begin
        want = expected_readings.pop_front();
        check_field("drive_low",   32'(want.drive_low),   32'(out_data.drive_low));
        check_field("busy_res",    32'(want.busy_res),    32'(out_data.busy_res));
        check_field("done_res",    32'(want.done_res),    32'(out_data.done_res));
        check_field("status",      32'(want.status),      32'(out_data.status));
        check_field("humidity",    32'(want.humidity),    32'(out_data.humidity));
        check_field("temperature", 32'(want.temperature), 32'(out_data.temperature));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  function automatic in_item_t make_item(input logic action, input logic pin);
    in_item_t txn;
    txn.action    = action;
    txn.pin_level = pin;
    return txn;
  endfunction

  // one input transaction: optional idle gap, then hold until accepted
  task automatic send_item(input in_item_t txn);
    out_item_t reading;
    int        gap;
    gap = 0;
    while (gap < 8 && $urandom_range(99) < tx_idle_pct) gap++;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= txn;
    do @(posedge clk); while (in_stall);
    reading = predict_reading(txn);
    expected_readings.push_back(reading);
    items_sent++;
  endtask

  // stop sending and let every owed reading come back
  task automatic await_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    await_quiet();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_START_LOW_TICKS: reader_cfg.start_low_ticks = value;
      REG_RELEASE_TICKS:   reader_cfg.release_ticks   = value[7:0];
      REG_LEVEL_TIMEOUT:   reader_cfg.level_timeout   = value[9:0];
      REG_ONE_THRESHOLD:   reader_cfg.one_threshold   = value[9:0];
      REG_HIGH_LIMIT:      reader_cfg.high_limit      = value[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all_regs(input int start_low, input int rel_ticks, input int timeout,
                                input int threshold, input int limit);
    write_reg(REG_START_LOW_TICKS, 16'(start_low));
    write_reg(REG_RELEASE_TICKS,   16'(rel_ticks));
    write_reg(REG_LEVEL_TIMEOUT,   16'(timeout));
    write_reg(REG_ONE_THRESHOLD,   16'(threshold));
    write_reg(REG_HIGH_LIMIT,      16'(limit));
  endtask

  // a sensor-side tick; now and then a stray request lands mid-read
  task automatic frame_tick(input logic pin);
    if (rd_phase != PH_IDLE && $urandom_range(99) < 3)
      send_item(make_item(1'b1, 1'($urandom_range(1))));
    send_item(make_item(1'b0, pin));
  endtask

  // wrong-level ticks then the awaited level; the chosen wait is made to time out
  task automatic send_wait(input logic lvl, input int wait_no, input int break_at,
                           output bit stop);
    int to;
    int wrong;
    to   = int'(reader_cfg.level_timeout);
    stop = 1'b0;
    if (wait_no == break_at) begin
      repeat (to + 1) frame_tick(~lvl);
      stop = 1'b1;
    end else begin
      wrong = 0;
      if ($urandom_range(3) == 0) wrong = $urandom_range(0, (to < 3) ? to : 3);
      if (to <= 16 && $urandom_range(7) == 0) wrong = to;
      repeat (wrong) frame_tick(~lvl);
      frame_tick(lvl);
    end
  endtask

  // number of high ticks in a data bit, never more than one past high_limit
  function automatic int pick_pulse(input logic one);
    int thr;
    int lim;
    int lo;
    int hi;
    thr = int'(reader_cfg.one_threshold);
    lim = int'(reader_cfg.high_limit);
    if (one) begin
      lo = thr + 1;
      hi = lim + 1;
      if (lo >= hi || $urandom_range(3) == 0) return hi;
      return $urandom_range(lo, (hi > lo + 3) ? lo + 3 : hi);
    end
    hi = (thr < lim + 1) ? thr : lim + 1;
    if (hi < 1) return 1;
    if ($urandom_range(3) == 0) return hi;
    return $urandom_range(1, hi);
  endfunction

  // whole read as the sensor would answer it; break_at picks a wait to starve
  // (0 response low, 1 response high, then low and high of each data bit)
  task automatic send_frame(input bit sum_ok, input int break_at);
    logic [7:0]  hum_int;
    logic [7:0]  hum_dec;
    logic [7:0]  tmp_int;
    logic [7:0]  tmp_dec;
    logic [7:0]  sum;
    logic [39:0] frame;
    bit          stop;
    int          pulse;
    hum_int = 8'($urandom_range(255));
    hum_dec = 8'($urandom_range(255));
    tmp_int = 8'($urandom_range(255));
    tmp_dec = 8'($urandom_range(255));
    sum     = hum_int + hum_dec + tmp_int + tmp_dec;
    if (!sum_ok) sum = 8'($urandom_range(255));
    frame = {hum_int, hum_dec, tmp_int, tmp_dec, sum};

    send_item(make_item(1'b1, 1'($urandom_range(1))));
    // start pulse and release: the line level is of no interest here
    repeat ((reader_cfg.start_low_ticks == 0) ? 1 : reader_cfg.start_low_ticks)
      frame_tick(1'($urandom_range(1)));
    repeat ((reader_cfg.release_ticks == 0) ? 1 : reader_cfg.release_ticks)
      frame_tick(1'($urandom_range(1)));

    send_wait(1'b0, 0, break_at, stop);
    if (stop) return;
    send_wait(1'b1, 1, break_at, stop);
    if (stop) return;
    for (int k = 0; k < FRAME_BITS; k++) begin
      send_wait(1'b0, 2 + 2 * k, break_at, stop);
      if (stop) return;
      send_wait(1'b1, 3 + 2 * k, break_at, stop);
      if (stop) return;
      pulse = pick_pulse(frame[39 - k]);
      repeat (pulse - 1) frame_tick(1'b1);
      // a pulse past the limit ends by itself, otherwise a low tick closes it
      if (pulse <= int'(reader_cfg.high_limit)) frame_tick(1'b0);
    end
  endtask

  // hold the line high until the reader gives up or finishes
  task automatic drain_to_idle();
    while (rd_phase != PH_IDLE) send_item(make_item(1'b0, 1'b1));
  endtask

  task automatic choose_settings();
    int thr;
    thr = $urandom_range(0, 4);
    write_all_regs($urandom_range(0, 3), $urandom_range(0, 3),
                   ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 4), thr,
                   ($urandom_range(3) == 0) ? $urandom_range(0, thr) : thr + $urandom_range(0, 4));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: idle outputs, the start pulse under the reset length, then
  // a response wait that runs out on the reset timeout
  task automatic test_reset_defaults();
    send_item(make_item(1'b0, 1'b0));
    send_item(make_item(1'b1, 1'b1));
    repeat (20) send_item(make_item(1'b0, 1'b1));
    // shorten start and release so the read moves on within a few ticks
    write_reg(REG_START_LOW_TICKS, 16'd20);
    write_reg(REG_RELEASE_TICKS,   16'd3);
    drain_to_idle();
  endtask

  // ticks with nothing in progress change nothing
  task automatic test_idle_ticks();
    send_item(make_item(1'b0, 1'b0));
    send_item(make_item(1'b0, 1'b1));
  endtask

  // zero-length start and release, then both response timeouts
  task automatic test_response_timeouts();
    write_all_regs(0, 0, 0, 0, 0);
    send_item(make_item(1'b1, 1'b0));
    send_item(make_item(1'b1, 1'b1));   // request while busy is ignored
    send_item(make_item(1'b0, 1'b0));
    send_item(make_item(1'b0, 1'b1));
    send_item(make_item(1'b0, 1'b1));   // no response low
    send_item(make_item(1'b1, 1'b1));
    send_item(make_item(1'b0, 1'b1));
    send_item(make_item(1'b0, 1'b0));
    send_item(make_item(1'b0, 1'b0));
    send_item(make_item(1'b0, 1'b0));   // no response high
  endtask

  // the low and the rising-edge wait of a data bit both time out
  task automatic test_bit_timeouts();
    send_item(make_item(1'b1, 1'b0));
    send_item(make_item(1'b0, 1'b1));
    send_item(make_item(1'b0, 1'b0));
    send_item(make_item(1'b0, 1'b0));
    send_item(make_item(1'b0, 1'b1));
    send_item(make_item(1'b0, 1'b1));   // bit low never comes
    send_item(make_item(1'b1, 1'b1));
    send_item(make_item(1'b0, 1'b0));
    send_item(make_item(1'b0, 1'b1));
    send_item(make_item(1'b0, 1'b0));
    send_item(make_item(1'b0, 1'b1));
    send_item(make_item(1'b0, 1'b0));
    send_item(make_item(1'b0, 1'b0));   // bit rising edge never comes
  endtask

  // every register at its top value; one short bit decodes as zero, then the
  // timing is pulled in so the read runs out on the next bit low wait
  task automatic test_max_settings();
    write_all_regs(16'hFFFF, 8'hFF, 10'h3FF, 10'h3FF, 10'h3FF);
    send_item(make_item(1'b1, 1'b0));
    repeat (8) send_item(make_item(1'b0, 1'b1));
    write_reg(REG_START_LOW_TICKS, 16'd8);
    write_reg(REG_RELEASE_TICKS,   16'd2);
    repeat (3) send_item(make_item(1'b0, 1'b1));
    send_item(make_item(1'b0, 1'b0));   // response low
    send_item(make_item(1'b0, 1'b1));   // response high
    send_item(make_item(1'b0, 1'b0));   // bit low
    send_item(make_item(1'b0, 1'b1));   // rising edge
    send_item(make_item(1'b0, 1'b1));
    send_item(make_item(1'b0, 1'b0));   // short pulse ends
    write_reg(REG_LEVEL_TIMEOUT, 16'd2);
    drain_to_idle();
  endtask

  // mostly well-formed reads with random content, some starved, some noise
  task automatic test_random_frames(input int tx_pct, input int rx_pct, input int amount);
    int target;
    int pick;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    choose_settings();
    target = items_sent + amount;
    while (items_sent < target) begin
      if ($urandom_range(3) == 0) choose_settings();
      repeat ($urandom_range(0, 2)) send_item(make_item(1'b0, 1'($urandom_range(1))));
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame($urandom_range(3) != 0, -1);
      end else if (pick < 90) begin
        send_frame(1'b1, $urandom_range(0, 81));
      end else begin
        repeat (12) send_item(make_item($urandom_range(9) == 0, 1'($urandom_range(1))));
        drain_to_idle();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    int waited;
    reader_cfg = '{start_low_ticks: RST_START_LOW_TICKS, release_ticks: RST_RELEASE_TICKS,
                   level_timeout: RST_LEVEL_TIMEOUT, one_threshold: RST_ONE_THRESHOLD,
                   high_limit: RST_HIGH_LIMIT};
    rd_phase  = PH_IDLE;
    rd_ticks  = '0;
    rd_bits   = '0;
    rd_frame  = '0;
    rd_status = ST_OK;
    rd_humid  = '0;
    rd_temp   = '0;
    rd_done   = 1'b0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed part under the first idling pattern
    tx_idle_pct  = 36;
    rx_stall_pct = 45;
    test_reset_defaults();
    test_idle_ticks();
    test_response_timeouts();
    test_bit_timeouts();
    test_max_settings();

    // random part: receiver-heavy stalls, sender-heavy idling, then flat out
    test_random_frames(36, 45, 300);
    test_random_frames(45, 36, 300);
    test_random_frames(0, 0, 300);

    // let every owed transaction drain, then a short tail for strays
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_readings.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_readings.size() != 0) begin
      $error("%0d readings never arrived", expected_readings.size());
      error_count++;
    end
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/swhr_pkg.sv
sv/swhr_cfg.sv
sv/swhr_core.sv
sv/swhr_obuf.sv
sv/single_wire_humidity_sensor_reader_top.sv
dv/single_wire_humidity_sensor_reader_top_test.sv
